/* rtl/length_prefixed_message_ring_assert.svh */
// Assertion macros for the message ring RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef LENGTH_PREFIXED_MESSAGE_RING_ASSERT_SVH
`define LENGTH_PREFIXED_MESSAGE_RING_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define LPMR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define LPMR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LPMR_ASSERT(lbl, prop, msg)

`define LPMR_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

/* rtl/lpmr_pkg.sv */
// Shared types and codes for the length-prefixed message ring.
// No dependencies; used by lpmr_ctrl, lpmr_datapath and the top level.
package lpmr_pkg;

    localparam int LEN_W = 15;

    localparam logic OP_PUT = 1'b0;
    localparam logic OP_GET = 1'b1;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_SPACE = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_TOO_LONG = 3'd3;
    localparam logic [2:0] ST_DROPPED  = 3'd4;

    typedef struct packed {
        logic             op;
        logic             put_first;
        logic [LEN_W-1:0] message_length;
        logic [7:0]       put_byte;
        logic [LEN_W-1:0] get_max_len;
    } in_item_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [7:0]       get_byte;
        logic [LEN_W-1:0] got_length;
        logic             last;
    } out_item_t;

    typedef struct packed {
        logic       item_load;
        logic       put_refuse;
        logic       put_start;
        logic       put_wr;
        logic       put_hdr;
        logic       put_dec;
        logic       put_commit;
        logic       get_start;
        logic       get_rd;
        logic       get_hdr;
        logic       get_open;
        logic       get_skip;
        logic       get_dec;
        logic       res_load;
        logic [2:0] res_status;
        logic       res_last;
        logic       res_byte;
        logic       res_hdrlen;
        logic       res_glen;
        logic       push;
    } cmd_t;

    typedef struct packed {
        logic op;
        logic put_first;
        logic put_ok;
        logic len_zero;
        logic put_open;
        logic empty;
        logic get_active;
        logic hdr_gt_max;
        logic hdr_zero;
        logic put_rem_one;
        logic get_rem_one;
    } sts_t;

endpackage

/* rtl/lpmr_ctrl.sv */
// Sequencer for the message ring: one item at a time, one memory access per cycle.
// Depends on lpmr_pkg; drives lpmr_datapath through cmd_t, reads sts_t.
module lpmr_ctrl #(
    parameter int HEADER_BYTES = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  lpmr_pkg::sts_t sts,
    output lpmr_pkg::cmd_t cmd
);

    localparam int CW = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
    localparam logic [CW-1:0] CNT_LAST = CW'(HEADER_BYTES - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_PUT_HDR,
        S_PUT_BYTE,
        S_PUT_COMMIT,
        S_GET_HDR,
        S_GET_WAIT,
        S_GET_EVAL,
        S_GET_BYTE,
        S_GET_DATA,
        S_DONE
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.item_load = 1'b1;
                    state_next    = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (sts.op == lpmr_pkg::OP_PUT)
                begin
                    if (sts.put_first && !sts.put_ok)
                    begin
                        cmd.put_refuse = 1'b1;
                        cmd.res_load   = 1'b1;
                        cmd.res_status = lpmr_pkg::ST_NO_SPACE;
                        state_next     = S_DONE;
                    end
                    else if (sts.put_first)
                    begin
                        cmd.put_start = 1'b1;
                        cnt_next      = '0;
                        state_next    = S_PUT_HDR;
                    end
                    else if (!sts.put_open)
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = lpmr_pkg::ST_DROPPED;
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        state_next = S_PUT_BYTE;
                    end
                end
                else
                begin
                    if (sts.get_active)
                    begin
                        state_next = S_GET_BYTE;
                    end
                    else if (sts.empty)
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = lpmr_pkg::ST_EMPTY;
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        cmd.get_start = 1'b1;
                        cnt_next      = '0;
                        state_next    = S_GET_HDR;
                    end
                end
            end
            S_PUT_HDR:
            begin
                cmd.put_wr  = 1'b1;
                cmd.put_hdr = 1'b1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = sts.len_zero ? S_PUT_COMMIT : S_PUT_BYTE;
                end
            end
            S_PUT_BYTE:
            begin
                cmd.put_wr  = 1'b1;
                cmd.put_dec = 1'b1;
                if (sts.put_rem_one)
                begin
                    state_next = S_PUT_COMMIT;
                end
                else
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = lpmr_pkg::ST_OK;
                    state_next     = S_DONE;
                end
            end
            S_PUT_COMMIT:
            begin
                cmd.put_commit = 1'b1;
                cmd.res_load   = 1'b1;
                cmd.res_status = lpmr_pkg::ST_OK;
                cmd.res_last   = 1'b1;
                state_next     = S_DONE;
            end
            S_GET_HDR:
            begin
                cmd.get_rd  = 1'b1;
                cmd.get_hdr = 1'b1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_GET_WAIT;
                end
            end
            S_GET_WAIT:
            begin
                state_next = S_GET_EVAL;
            end
            S_GET_EVAL:
            begin
                if (sts.hdr_gt_max)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = lpmr_pkg::ST_TOO_LONG;
                    cmd.res_hdrlen = 1'b1;
                    state_next     = S_DONE;
                end
                else if (sts.hdr_zero)
                begin
                    cmd.get_skip   = 1'b1;
                    cmd.res_load   = 1'b1;
                    cmd.res_status = lpmr_pkg::ST_OK;
                    cmd.res_last   = 1'b1;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.get_open = 1'b1;
                    state_next   = S_GET_BYTE;
                end
            end
            S_GET_BYTE:
            begin
                cmd.get_rd = 1'b1;
                state_next = S_GET_DATA;
            end
            S_GET_DATA:
            begin
                cmd.get_dec    = 1'b1;
                cmd.res_load   = 1'b1;
                cmd.res_status = lpmr_pkg::ST_OK;
                cmd.res_byte   = 1'b1;
                cmd.res_glen   = 1'b1;
                cmd.res_last   = sts.get_rem_one;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.push       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/lpmr_datapath.sv */
// Byte store, ring pointers, put/get progress registers and the result registers.
// Depends on lpmr_pkg and length_prefixed_message_ring_assert.svh; driven by lpmr_ctrl.
`include "length_prefixed_message_ring_assert.svh"

module lpmr_datapath #(
    parameter int BUFFER_BYTES = 32768,
    parameter int HEADER_BYTES = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lpmr_pkg::in_item_t  in_data,
    input  lpmr_pkg::cmd_t      cmd,
    output lpmr_pkg::sts_t      sts,
    output lpmr_pkg::out_item_t out_data
);

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int PW = $clog2(2 * BUFFER_BYTES);
    localparam int SW = ((PW > 16) ? PW : 16) + 2;
    localparam int HW = 8 * HEADER_BYTES;
    localparam int LW = lpmr_pkg::LEN_W;

    localparam logic [SW-1:0] BUF_S  = SW'(BUFFER_BYTES);
    localparam logic [SW-1:0] MOD_S  = SW'(2 * BUFFER_BYTES);
    localparam logic [SW-1:0] HDR_S  = SW'(HEADER_BYTES);
    localparam logic [PW-1:0] BUF_P  = PW'(BUFFER_BYTES);
    localparam logic [AW-1:0] LAST_A = AW'(BUFFER_BYTES - 1);

    function automatic logic [AW-1:0] idx_of(input logic [PW-1:0] p);
        return (p >= BUF_P) ? AW'(p - BUF_P) : AW'(p);
    endfunction

    function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
        return (a == LAST_A) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [PW-1:0] ptr_add(input logic [PW-1:0] p, input logic [SW-1:0] amt);
        logic [SW-1:0] s;
        s = SW'(p) + amt;
        return (s >= MOD_S) ? PW'(s - MOD_S) : PW'(s);
    endfunction

    logic [7:0] mem [BUFFER_BYTES];
    logic [7:0] mem_q_reg;

    lpmr_pkg::in_item_t  item_reg;
    lpmr_pkg::out_item_t res_reg;
    lpmr_pkg::out_item_t out_reg;

    logic [PW-1:0] wp_reg;
    logic [PW-1:0] rp_reg;
    logic [PW-1:0] put_off_reg;
    logic [LW-1:0] put_rem_reg;
    logic          put_refused_reg;
    logic [AW-1:0] put_addr_reg;
    logic [HW-1:0] wsh_reg;
    logic [LW-1:0] get_rem_reg;
    logic [LW-1:0] get_len_reg;
    logic          get_active_reg;
    logic [AW-1:0] rd_addr_reg;
    logic [HW-1:0] hdr_reg;
    logic          cap_reg;

    logic [SW-1:0] used_w;
    logic [SW-1:0] need_w;
    logic [31:0]   len32;
    logic [31:0]   hdr32;
    logic [31:0]   max32;
    logic          hdr_ok;
    logic [7:0]    wdata;

    assign used_w = (wp_reg >= rp_reg) ? SW'(wp_reg) - SW'(rp_reg)
                                       : SW'(wp_reg) + MOD_S - SW'(rp_reg);
    assign need_w = SW'(item_reg.message_length) + HDR_S + used_w;
    assign len32  = 32'(item_reg.message_length);
    assign hdr32  = 32'(hdr_reg);
    assign max32  = 32'(item_reg.get_max_len);
    // length fits in the header width
    assign hdr_ok = ((len32 >> HW) == 32'd0);
    assign wdata  = cmd.put_hdr ? wsh_reg[7:0] : item_reg.put_byte;

    assign sts.op          = item_reg.op;
    assign sts.put_first   = item_reg.put_first;
    assign sts.put_ok      = (need_w <= BUF_S) && hdr_ok;
    assign sts.len_zero    = (item_reg.message_length == '0);
    assign sts.put_open    = !put_refused_reg && (put_rem_reg != '0);
    assign sts.empty       = (rp_reg == wp_reg);
    assign sts.get_active  = get_active_reg;
    assign sts.hdr_gt_max  = (hdr32 > max32);
    assign sts.hdr_zero    = (hdr_reg == '0);
    assign sts.put_rem_one = (put_rem_reg == LW'(1));
    assign sts.get_rem_one = (get_rem_reg == LW'(1));

    assign out_data = out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.put_wr)
        begin
            mem[put_addr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.get_rd)
        begin
            mem_q_reg <= mem[rd_addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg          <= '0;
            rp_reg          <= '0;
            put_off_reg     <= '0;
            put_rem_reg     <= '0;
            put_refused_reg <= 1'b0;
            get_rem_reg     <= '0;
            get_active_reg  <= 1'b0;
            cap_reg         <= 1'b0;
        end
        else
        begin
            cap_reg <= cmd.get_rd && cmd.get_hdr;
            if (cmd.put_refuse)
            begin
                put_refused_reg <= 1'b1;
                put_rem_reg     <= '0;
                put_off_reg     <= '0;
            end
            if (cmd.put_start)
            begin
                put_refused_reg <= 1'b0;
                put_rem_reg     <= item_reg.message_length;
                put_off_reg     <= '0;
            end
            if (cmd.put_wr)
            begin
                put_off_reg <= put_off_reg + 1'b1;
            end
            if (cmd.put_dec)
            begin
                put_rem_reg <= put_rem_reg - 1'b1;
            end
            if (cmd.put_commit)
            begin
                wp_reg      <= ptr_add(wp_reg, SW'(put_off_reg));
                put_off_reg <= '0;
                put_rem_reg <= '0;
            end
            if (cmd.get_open)
            begin
                get_active_reg <= 1'b1;
                get_rem_reg    <= LW'(hdr32);
            end
            if (cmd.get_skip)
            begin
                rp_reg <= ptr_add(rp_reg, HDR_S);
            end
            if (cmd.get_dec)
            begin
                get_rem_reg <= get_rem_reg - 1'b1;
                if (get_rem_reg == LW'(1))
                begin
                    get_active_reg <= 1'b0;
                    rp_reg         <= ptr_add(rp_reg, HDR_S + SW'(get_len_reg));
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            item_reg <= in_data;
        end
        if (cmd.put_start)
        begin
            put_addr_reg <= idx_of(wp_reg);
            wsh_reg      <= HW'(len32);
        end
        if (cmd.put_wr)
        begin
            put_addr_reg <= addr_inc(put_addr_reg);
            if (cmd.put_hdr)
            begin
                wsh_reg <= wsh_reg >> 8;
            end
        end
        if (cmd.get_start)
        begin
            rd_addr_reg <= idx_of(rp_reg);
        end
        if (cmd.get_rd)
        begin
            rd_addr_reg <= addr_inc(rd_addr_reg);
        end
        // little-endian: each new byte enters at the top
        if (cap_reg)
        begin
            hdr_reg <= (hdr_reg >> 8) | (HW'(mem_q_reg) << (HW - 8));
        end
        if (cmd.get_open)
        begin
            get_len_reg <= LW'(hdr32);
        end
        if (cmd.res_load)
        begin
            res_reg.status     <= cmd.res_status;
            res_reg.get_byte   <= cmd.res_byte ? mem_q_reg : 8'd0;
            res_reg.got_length <= cmd.res_hdrlen ? LW'(hdr32) :
                                  cmd.res_glen   ? get_len_reg : '0;
            res_reg.last       <= cmd.res_last;
        end
        if (cmd.push)
        begin
            out_reg <= res_reg;
        end
    end

    `LPMR_ASSERT(a_refused_no_rem, put_refused_reg |-> (put_rem_reg == '0), "refused put has bytes left")
    `LPMR_ASSERT(a_active_has_rem, get_active_reg |-> (get_rem_reg != '0), "open get with no bytes left")
    `LPMR_ASSERT(a_ptr_range, (SW'(wp_reg) < MOD_S) && (SW'(rp_reg) < MOD_S), "ring pointer out of range")
    `LPMR_ASSERT(a_used_bound, used_w <= BUF_S, "ring holds more than its size")
    `LPMR_ASSERT(a_one_port, cmd.put_wr |-> !cmd.get_rd, "store written and read in one cycle")

endmodule

/* rtl/length_prefixed_message_ring.sv */
// Length-prefixed message ring. One input channel (in_valid/in_ready/in_data)
// carries put and get items; one output channel (out_valid/out_ready/out_data)
// returns exactly one result per item, in order.
// A put stores one body byte; a put with put_first writes the HEADER_BYTES length
// header first. A get pops one body byte; the first get of a message reads the header.
// Items are handled one at a time through a single-port byte store, one access per
// cycle. in_ready is high only while the block is idle. A put start writes the
// header bytes, then its first body byte unless the length is zero; the byte that
// completes the message also commits it. A get start reads the header and checks
// it against get_max_len before it reads the first body byte; a too long or
// zero-length header ends the item without a byte read. The next item is accepted
// the cycle after its predecessor's result is loaded into the output register.
// If out_ready is low, a result waits in the output register; a second finished
// result holds the block until the first is taken. Reset empties the ring and
// clears all put and get progress; no clearing pass is needed.
module length_prefixed_message_ring #(
    parameter int BUFFER_BYTES = 32768,
    parameter int HEADER_BYTES = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  lpmr_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output lpmr_pkg::out_item_t out_data
);

    lpmr_pkg::cmd_t cmd;
    lpmr_pkg::sts_t sts;

    lpmr_ctrl #(
        .HEADER_BYTES(HEADER_BYTES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lpmr_datapath #(
        .BUFFER_BYTES(BUFFER_BYTES),
        .HEADER_BYTES(HEADER_BYTES)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_data (in_data),
        .cmd     (cmd),
        .sts     (sts),
        .out_data(out_data)
    );

endmodule

/* bench/length_prefixed_message_ring_tb.sv */
// Self-checking bench for length_prefixed_message_ring: a directed table and random
// put/get traffic, checked against a local ring.
// Depends on lpmr_pkg and the RTL top level only.
module length_prefixed_message_ring_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_BYTES = 32768;
    localparam int RING_AW    = $clog2(RING_BYTES);
    localparam int HDR_BYTES  = 4;
    localparam int MAX_LEN    = 32764;
    localparam int LEN_W      = lpmr_pkg::LEN_W;

    typedef struct {
        lpmr_pkg::in_item_t  item;
        bit                  typed;
        lpmr_pkg::out_item_t want;
    } stim_row_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    lpmr_pkg::in_item_t  in_data   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    lpmr_pkg::out_item_t out_data;

    // local copy of the ring
    logic [7:0]  ring_mem [RING_BYTES];
    logic [15:0] wr_ptr      = '0;
    logic [15:0] rd_ptr      = '0;
    logic [15:0] put_off     = '0;
    int          put_left    = 0;
    bit          put_refused = 1'b0;
    int          get_left    = 0;
    int          get_len     = 0;
    bit          reading     = 1'b0;

    lpmr_pkg::out_item_t pending_replies [$];
    stim_row_t           dir_rows [$];
    int                  bad_count  = 0;
    int                  pend_bytes = 0;
    int                  stall_left = 0;
    bit                  idle_on    = 1'b1;

    length_prefixed_message_ring dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #2 clk = ~clk;

    function automatic logic [RING_AW-1:0] slot_of(logic [15:0] ptr, int off);
        return RING_AW'((int'(ptr) + off) % RING_BYTES);
    endfunction

    function automatic lpmr_pkg::out_item_t ring_apply(lpmr_pkg::in_item_t it);
        lpmr_pkg::out_item_t r;
        logic [15:0]         used;
        logic [31:0]         hdr_len;
        bit                  take;
        bit                  counted;
        r = '0;
        r.status = lpmr_pkg::ST_OK;
        take = 1'b0;
        counted = 1'b0;
        if (it.op == lpmr_pkg::OP_PUT)
        begin
            if (it.put_first)
            begin
                used = wr_ptr - rd_ptr;
                put_left = 0;
                put_off = '0;
                if (int'(it.message_length) + HDR_BYTES > RING_BYTES - int'(used))
                begin
                    put_refused = 1'b1;
                    r.status = lpmr_pkg::ST_NO_SPACE;
                end
                else
                begin
                    put_refused = 1'b0;
                    for (int i = 0; i < HDR_BYTES; i++)
                        ring_mem[slot_of(wr_ptr, i)] = 8'(32'(it.message_length) >> (8 * i));
                    put_off = 16'(HDR_BYTES);
                    put_left = int'(it.message_length);
                    take = (put_left != 0);
                    counted = 1'b1;
                end
            end
            else if (put_refused || put_left == 0)
                r.status = lpmr_pkg::ST_DROPPED;
            else
            begin
                take = 1'b1;
                counted = 1'b1;
            end
            if (take)
            begin
                ring_mem[slot_of(wr_ptr, int'(put_off))] = it.put_byte;
                put_off = put_off + 16'd1;
                put_left--;
            end
            if (counted && put_left == 0)
            begin
                wr_ptr = wr_ptr + put_off;
                put_off = '0;
                r.last = 1'b1;
            end
        end
        else
        begin
            if (!reading)
            begin
                if (rd_ptr == wr_ptr)
                    r.status = lpmr_pkg::ST_EMPTY;
                else
                begin
                    hdr_len = '0;
                    for (int i = 0; i < HDR_BYTES; i++)
                        hdr_len = hdr_len | (32'(ring_mem[slot_of(rd_ptr, i)]) << (8 * i));
                    if (hdr_len > it.get_max_len)
                    begin
                        r.status = lpmr_pkg::ST_TOO_LONG;
                        r.got_length = hdr_len[LEN_W-1:0];
                    end
                    else if (hdr_len == 0)
                    begin
                        rd_ptr = rd_ptr + 16'(HDR_BYTES);
                        r.last = 1'b1;
                    end
                    else
                    begin
                        get_len = int'(hdr_len);
                        get_left = get_len;
                        reading = 1'b1;
                    end
                end
            end
            if (reading)
            begin
                r.get_byte = ring_mem[slot_of(rd_ptr, HDR_BYTES + get_len - get_left)];
                r.got_length = LEN_W'(get_len);
                get_left--;
                if (get_left == 0)
                begin
                    rd_ptr = rd_ptr + 16'(HDR_BYTES + get_len);
                    reading = 1'b0;
                    r.last = 1'b1;
                end
            end
        end
        return r;
    endfunction

    function automatic lpmr_pkg::in_item_t rand_item();
        lpmr_pkg::in_item_t it;
        it.op = 1'($urandom);
        it.put_first = 1'($urandom);
        it.message_length = LEN_W'($urandom_range(0, MAX_LEN));
        it.put_byte = 8'($urandom);
        it.get_max_len = LEN_W'($urandom_range(0, MAX_LEN));
        return it;
    endfunction

    // mostly well-formed puts and reads, with abandoned puts and some noise
    function automatic lpmr_pkg::in_item_t next_random_item();
        lpmr_pkg::in_item_t it;
        int                 pick;
        int                 len;
        it = rand_item();
        pick = $urandom_range(0, 99);
        if (pend_bytes > 0 && pick < 55)
        begin
            it.op = lpmr_pkg::OP_PUT;
            it.put_first = 1'b0;
            pend_bytes--;
        end
        else if (pick < 70)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                len = $urandom_range(0, 12);
            else if (pick < 9)
                len = $urandom_range(13, 64);
            else
                len = $urandom_range(0, MAX_LEN);
            it.op = lpmr_pkg::OP_PUT;
            it.put_first = 1'b1;
            it.message_length = LEN_W'(len);
            if (len > 64)
                pend_bytes = $urandom_range(0, 3);
            else
                pend_bytes = (len == 0) ? 0 : len - 1;
        end
        else if (pick < 95)
        begin
            it.op = lpmr_pkg::OP_GET;
            pick = $urandom_range(0, 4);
            if (pick < 3)
                it.get_max_len = LEN_W'(MAX_LEN);
            else if (pick == 3)
                it.get_max_len = LEN_W'($urandom_range(0, 16));
        end
        else if (it.op == lpmr_pkg::OP_PUT && it.put_first)
            pend_bytes = 0;
        return it;
    endfunction

    task automatic add_row(logic op, logic first, int len, logic [7:0] data, int maxlen,
                           bit typed = 1'b0, logic [2:0] st = lpmr_pkg::ST_OK,
                           logic [7:0] gb = '0, int gl = 0, logic lst = 1'b0);
        stim_row_t row;
        row.item = '{op, first, LEN_W'(len), data, LEN_W'(maxlen)};
        row.typed = typed;
        row.want = '{st, gb, LEN_W'(gl), lst};
        dir_rows.push_back(row);
    endtask

    task automatic send_item(lpmr_pkg::in_item_t it, bit typed = 1'b0,
                             lpmr_pkg::out_item_t want = '0);
        lpmr_pkg::out_item_t guess;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        guess = ring_apply(it);
        pending_replies.push_back(typed ? want : guess);
    endtask

    task automatic run_random(int count, bit with_idle);
        for (int n = 0; n < count; n++)
        begin
            if (n % 100 == 0)
                idle_on = with_idle && ($urandom_range(0, 2) != 0);
            send_item(next_random_item());
        end
    endtask

    // values in field order: status, byte, length, last
    task automatic note_bad(string what, lpmr_pkg::out_item_t exp_r,
                            lpmr_pkg::out_item_t got_r);
        bad_count++;
        if (bad_count <= 10)
            $display("%0t %s: expected %0d %02h %0d %b, got %0d %02h %0d %b",
                     $realtime, what, exp_r.status, exp_r.get_byte, exp_r.got_length,
                     exp_r.last, got_r.status, got_r.get_byte, got_r.got_length, got_r.last);
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 8);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        lpmr_pkg::out_item_t want;
        if (out_valid && out_ready)
        begin
            if (pending_replies.size() == 0)
                note_bad("result with no item pending", '0, out_data);
            else
            begin
                want = pending_replies.pop_front();
                if (out_data.status !== want.status || out_data.get_byte !== want.get_byte
                    || out_data.got_length !== want.got_length || out_data.last !== want.last)
                    note_bad("result differs", want, out_data);
            end
        end
    end

    initial
    begin
        add_row(lpmr_pkg::OP_GET, 1'b0, 0, 8'h00, MAX_LEN, 1'b1, lpmr_pkg::ST_EMPTY);
        add_row(lpmr_pkg::OP_PUT, 1'b0, 0, 8'hFF, 0, 1'b1, lpmr_pkg::ST_DROPPED);
        add_row(lpmr_pkg::OP_PUT, 1'b1, 0, 8'hFF, 0, 1'b1, lpmr_pkg::ST_OK, 8'h00, 0, 1'b1);
        add_row(lpmr_pkg::OP_GET, 1'b0, 0, 8'h00, 0, 1'b1, lpmr_pkg::ST_OK, 8'h00, 0, 1'b1);
        add_row(lpmr_pkg::OP_GET, 1'b1, MAX_LEN, 8'hFF, MAX_LEN, 1'b1, lpmr_pkg::ST_EMPTY);
        add_row(lpmr_pkg::OP_PUT, 1'b1, 3, 8'hFF, MAX_LEN);
        add_row(lpmr_pkg::OP_PUT, 1'b0, MAX_LEN, 8'h00, 0);
        add_row(lpmr_pkg::OP_PUT, 1'b0, 0, 8'hA5, 0);
        add_row(lpmr_pkg::OP_GET, 1'b0, 0, 8'h00, 2, 1'b1, lpmr_pkg::ST_TOO_LONG, 8'h00, 3);
        add_row(lpmr_pkg::OP_GET, 1'b0, 0, 8'h00, 3);
        add_row(lpmr_pkg::OP_GET, 1'b1, 0, 8'hFF, 3);
        add_row(lpmr_pkg::OP_GET, 1'b0, 0, 8'h00, MAX_LEN);
        add_row(lpmr_pkg::OP_PUT, 1'b1, 1, 8'h5A, 0);
        add_row(lpmr_pkg::OP_PUT, 1'b1, 5, 8'h11, 0);
        add_row(lpmr_pkg::OP_PUT, 1'b0, 0, 8'h22, 0);
        add_row(lpmr_pkg::OP_PUT, 1'b1, 2, 8'h33, 0);
        add_row(lpmr_pkg::OP_PUT, 1'b0, 0, 8'h44, 0);
        add_row(lpmr_pkg::OP_PUT, 1'b0, 0, 8'h55, 0, 1'b1, lpmr_pkg::ST_DROPPED);
        add_row(lpmr_pkg::OP_PUT, 1'b1, MAX_LEN, 8'h00, MAX_LEN, 1'b1, lpmr_pkg::ST_NO_SPACE);
        add_row(lpmr_pkg::OP_PUT, 1'b0, 0, 8'h66, 0, 1'b1, lpmr_pkg::ST_DROPPED);
        add_row(lpmr_pkg::OP_GET, 1'b0, 0, 8'h00, MAX_LEN);
        add_row(lpmr_pkg::OP_GET, 1'b0, 0, 8'h00, MAX_LEN);
        add_row(lpmr_pkg::OP_GET, 1'b0, 0, 8'h00, MAX_LEN);
        add_row(lpmr_pkg::OP_GET, 1'b0, 0, 8'h00, MAX_LEN, 1'b1, lpmr_pkg::ST_EMPTY);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (dir_rows[i])
            send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
        run_random(1000, 1'b1);
        idle_on = 1'b0;
        run_random(600, 1'b0);
        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (bad_count == 0 && pending_replies.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/lpmr_pkg.sv
rtl/lpmr_ctrl.sv
rtl/lpmr_datapath.sv
rtl/length_prefixed_message_ring.sv
bench/length_prefixed_message_ring_tb.sv
